@@ design/rkd_pkg.sv @@
// Package for the RSA key derivation block: payload structs, datapath
// commands, controller states and shared constants.
// No dependencies.
package rkd_pkg;

  localparam int WORD_W     = 64;
  localparam int HALF_W     = 32;
  localparam int DIV_STEPS  = 64;
  localparam int DIV_CNT_W  = 7;
  localparam logic [HALF_W-1:0] E_RESET = 32'h0001_0001;

  typedef struct packed {
    logic [HALF_W-1:0] prime_p;
    logic [HALF_W-1:0] prime_q;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0] modulus;
    logic [62:0]       private_exponent;
    logic [HALF_W-1:0] exponent_p;
    logic [HALF_W-1:0] exponent_q;
    logic [HALF_W-1:0] crt_coefficient;
    logic              modulus_full_width;
    logic              not_coprime;
    logic              input_error;
  } result_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_N,
    OP_SET_N,
    OP_GCD_INIT,
    OP_GCD_DIV,
    OP_GCD_STEP,
    OP_LAM_DIV,
    OP_LAM_MUL,
    OP_SET_LAM,
    OP_INV1_INIT,
    OP_INV2_INIT,
    OP_INV_DIV,
    OP_INV_MUL,
    OP_INV_STEP,
    OP_FIX,
    OP_FIX_DIV,
    OP_FIX_REM,
    OP_SET_D,
    OP_EP_DIV,
    OP_SET_EP,
    OP_EQ_DIV,
    OP_SET_EQ,
    OP_SET_CO,
    OP_OUT
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_N_WAIT,
    S_GCD_INIT,
    S_GCD_TEST,
    S_GCD_DIVW,
    S_LAM_DIVW,
    S_LAM_MULW,
    S_INV1_INIT,
    S_INV_TEST,
    S_INV_DIVW,
    S_INV_MULW,
    S_FIX_TEST,
    S_FIX_DIVW,
    S_STORE,
    S_EP,
    S_EP_W,
    S_EQ,
    S_EQ_W,
    S_INV2_INIT,
    S_OUT
  } state_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic in_err;
    logic nr_zero;
    logic x_ge_m;
    logic div_busy;
    logic mul_busy;
  } dp_status_t;

endpackage

@@ design/rkd_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on rkd_pkg.
module rkd_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rkd_pkg::WORD_W-1:0] dividend,
  input  logic [rkd_pkg::WORD_W-1:0] divisor,
  output logic [rkd_pkg::WORD_W-1:0] quotient,
  output logic [rkd_pkg::WORD_W-1:0] remainder,
  output logic                       busy
);

  logic [rkd_pkg::DIV_CNT_W-1:0] cnt;
  logic [rkd_pkg::WORD_W-1:0]    dvs;
  logic [rkd_pkg::WORD_W:0]      trial;
  logic                          fits;

  // shift the next dividend bit into the partial remainder
  assign trial = {remainder, quotient[rkd_pkg::WORD_W-1]};
  assign fits  = trial >= {1'b0, dvs};
  assign busy  = cnt != '0;

  // count down the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= rkd_pkg::DIV_CNT_W'(rkd_pkg::DIV_STEPS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  // subtract where the divisor fits, record the quotient bit
  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      quotient  <= dividend;
      dvs       <= divisor;
    end else if (busy) begin
      if (fits) begin
        remainder <= rkd_pkg::WORD_W'(trial - {1'b0, dvs});
      end else begin
        remainder <= trial[rkd_pkg::WORD_W-1:0];
      end
      quotient <= {quotient[rkd_pkg::WORD_W-2:0], fits};
    end
  end

endmodule

@@ design/rkd_mul.sv @@
// Shift-and-add multiplier, product modulo 2^64; stops once the multiplier
// bits run out, so a small multiplier finishes early.
// Depends on rkd_pkg.
module rkd_mul (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rkd_pkg::WORD_W-1:0] mcand,
  input  logic [rkd_pkg::WORD_W-1:0] mplier,
  output logic [rkd_pkg::WORD_W-1:0] product,
  output logic                       busy
);

  logic [rkd_pkg::WORD_W-1:0] cand;
  logic [rkd_pkg::WORD_W-1:0] rest;

  assign busy = rest != '0;

  // drain the multiplier bits
  always_ff @(posedge clk) begin
    if (rst) begin
      rest <= '0;
    end else if (start) begin
      rest <= mplier;
    end else if (busy) begin
      rest <= rest >> 1;
    end
  end

  // accumulate the shifted multiplicand
  always_ff @(posedge clk) begin
    if (start) begin
      product <= '0;
      cand    <= mcand;
    end else if (busy) begin
      if (rest[0]) begin
        product <= product + cand;
      end
      cand <= cand << 1;
    end
  end

endmodule

@@ design/rkd_dp.sv @@
// Datapath: operand registers, the divider and multiplier, result register.
// Depends on rkd_pkg, rkd_div and rkd_mul.
module rkd_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  rkd_pkg::dp_cmd_t           cmd,
  output rkd_pkg::dp_status_t        status,
  input  rkd_pkg::item_t             item,
  input  logic                       cfg_valid,
  input  logic [rkd_pkg::HALF_W-1:0] cfg_data,
  output logic                       done,
  output rkd_pkg::result_t           result
);

  logic [rkd_pkg::HALF_W-1:0] e;
  logic [rkd_pkg::HALF_W-1:0] p, q, pm1, qm1;
  logic [rkd_pkg::HALF_W-1:0] ep, eq, co;
  logic [rkd_pkg::WORD_W-1:0] n, m, r, nr, t, nt, x, d;
  logic                       steps_nz, par, bad, err;

  logic                       div_start, div_busy;
  logic [rkd_pkg::WORD_W-1:0] div_a, div_b, div_q, div_r;
  logic                       mul_start, mul_busy;
  logic [rkd_pkg::WORD_W-1:0] mul_a, mul_b, mul_p;

  rkd_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(div_b),
    .quotient(div_q), .remainder(div_r), .busy(div_busy)
  );

  rkd_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .mcand(mul_a), .mplier(mul_b),
    .product(mul_p), .busy(mul_busy)
  );

  // select unit operands for the command
  always_comb begin
    div_start = 1'b1;
    div_a     = r;
    div_b     = nr;
    case (cmd.op)
      rkd_pkg::OP_GCD_DIV, rkd_pkg::OP_INV_DIV: begin
        div_a = r;
        div_b = nr;
      end
      rkd_pkg::OP_LAM_DIV: begin
        div_a = {32'd0, pm1};
        div_b = r;
      end
      rkd_pkg::OP_FIX_DIV: begin
        div_a = x;
        div_b = m;
      end
      rkd_pkg::OP_EP_DIV: begin
        div_a = d;
        div_b = {32'd0, pm1};
      end
      rkd_pkg::OP_EQ_DIV: begin
        div_a = d;
        div_b = {32'd0, qm1};
      end
      default: div_start = 1'b0;
    endcase
  end

  always_comb begin
    mul_start = 1'b1;
    mul_a     = nt;
    mul_b     = div_q;
    case (cmd.op)
      rkd_pkg::OP_MUL_N: begin
        mul_a = {32'd0, p};
        mul_b = {32'd0, q};
      end
      rkd_pkg::OP_LAM_MUL: begin
        mul_a = {32'd0, qm1};
        mul_b = div_q;
      end
      rkd_pkg::OP_INV_MUL: begin
        mul_a = nt;
        mul_b = div_q;
      end
      default: mul_start = 1'b0;
    endcase
  end

  // hold the public exponent
  always_ff @(posedge clk) begin
    if (rst) begin
      e <= rkd_pkg::E_RESET;
    end else if (cfg_valid) begin
      e <= cfg_data;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.op == rkd_pkg::OP_OUT;
    end
  end

  // update operand registers per command
  always_ff @(posedge clk) begin
    case (cmd.op)
      rkd_pkg::OP_LOAD: begin
        p   <= item.prime_p;
        q   <= item.prime_q;
        pm1 <= item.prime_p - 1'b1;
        qm1 <= item.prime_q - 1'b1;
        err <= (item.prime_p < 32'd2) || (item.prime_q < 32'd2);
        bad <= 1'b0;
      end
      rkd_pkg::OP_SET_N:    n <= mul_p;
      rkd_pkg::OP_GCD_INIT: begin
        r  <= {32'd0, pm1};
        nr <= {32'd0, qm1};
      end
      rkd_pkg::OP_GCD_STEP: begin
        r  <= nr;
        nr <= div_r;
      end
      rkd_pkg::OP_SET_LAM:  m <= mul_p;
      rkd_pkg::OP_INV1_INIT: begin
        r        <= m;
        nr       <= {32'd0, e};
        t        <= '0;
        nt       <= 64'd1;
        steps_nz <= 1'b0;
        par      <= 1'b0;
      end
      rkd_pkg::OP_INV2_INIT: begin
        m        <= {32'd0, p};
        r        <= {32'd0, p};
        nr       <= {32'd0, q};
        t        <= '0;
        nt       <= 64'd1;
        steps_nz <= 1'b0;
        par      <= 1'b0;
      end
      rkd_pkg::OP_INV_STEP: begin
        r        <= nr;
        nr       <= div_r;
        t        <= nt;
        nt       <= t + mul_p;
        steps_nz <= 1'b1;
        par      <= ~par;
      end
      rkd_pkg::OP_FIX: begin
        // an even nonzero step count means a negative coefficient: wrap it
        x   <= (steps_nz && !par) ? m - t : t;
        bad <= bad | (r != 64'd1);
      end
      rkd_pkg::OP_FIX_REM: x  <= div_r;
      rkd_pkg::OP_SET_D:   d  <= x;
      rkd_pkg::OP_SET_EP:  ep <= div_r[rkd_pkg::HALF_W-1:0];
      rkd_pkg::OP_SET_EQ:  eq <= div_r[rkd_pkg::HALF_W-1:0];
      rkd_pkg::OP_SET_CO:  co <= x[rkd_pkg::HALF_W-1:0];
      rkd_pkg::OP_OUT: begin
        // a bad factor clears every field but the error flag
        if (err) begin
          result <= '{modulus: '0, private_exponent: '0, exponent_p: '0,
                      exponent_q: '0, crt_coefficient: '0,
                      modulus_full_width: 1'b0, not_coprime: 1'b0,
                      input_error: 1'b1};
        end else begin
          result <= '{modulus: n, private_exponent: d[62:0], exponent_p: ep,
                      exponent_q: eq, crt_coefficient: co,
                      modulus_full_width: n[rkd_pkg::WORD_W-1],
                      not_coprime: bad, input_error: 1'b0};
        end
      end
      default: ;
    endcase
  end

  assign status.in_err   = err;
  assign status.nr_zero  = nr == '0;
  assign status.x_ge_m   = x >= m;
  assign status.div_busy = div_busy;
  assign status.mul_busy = mul_busy;

`ifndef SYNTHESIS
  a_div_no_restart: assert property (@(posedge clk) disable iff (rst)
    !(div_start && div_busy)) else $error("division started while busy");
  a_mul_no_restart: assert property (@(posedge clk) disable iff (rst)
    !(mul_start && mul_busy)) else $error("multiply started while busy");
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");
`endif

endmodule

@@ design/rkd_ctrl.sv @@
// Controller: sequences gcd, lcm, both inverses and the CRT reductions.
// Depends on rkd_pkg.
module rkd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  output rkd_pkg::dp_cmd_t    cmd,
  input  rkd_pkg::dp_status_t status
);

  rkd_pkg::state_t state, state_next;
  logic            phase, phase_next;

  assign busy = state != rkd_pkg::S_IDLE;

  // advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rkd_pkg::S_IDLE;
      phase <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    phase_next = phase;
    case (state)
      rkd_pkg::S_IDLE:      if (start) state_next = rkd_pkg::S_CHECK;
      rkd_pkg::S_CHECK:
        state_next = status.in_err ? rkd_pkg::S_OUT : rkd_pkg::S_N_WAIT;
      rkd_pkg::S_N_WAIT:    if (!status.mul_busy) state_next = rkd_pkg::S_GCD_INIT;
      rkd_pkg::S_GCD_INIT:  state_next = rkd_pkg::S_GCD_TEST;
      rkd_pkg::S_GCD_TEST:
        state_next = status.nr_zero ? rkd_pkg::S_LAM_DIVW : rkd_pkg::S_GCD_DIVW;
      rkd_pkg::S_GCD_DIVW:  if (!status.div_busy) state_next = rkd_pkg::S_GCD_TEST;
      rkd_pkg::S_LAM_DIVW:  if (!status.div_busy) state_next = rkd_pkg::S_LAM_MULW;
      rkd_pkg::S_LAM_MULW:  if (!status.mul_busy) state_next = rkd_pkg::S_INV1_INIT;
      rkd_pkg::S_INV1_INIT: begin
        state_next = rkd_pkg::S_INV_TEST;
        phase_next = 1'b0;
      end
      rkd_pkg::S_INV_TEST:
        state_next = status.nr_zero ? rkd_pkg::S_FIX_TEST : rkd_pkg::S_INV_DIVW;
      rkd_pkg::S_INV_DIVW:  if (!status.div_busy) state_next = rkd_pkg::S_INV_MULW;
      rkd_pkg::S_INV_MULW:  if (!status.mul_busy) state_next = rkd_pkg::S_INV_TEST;
      rkd_pkg::S_FIX_TEST:
        state_next = status.x_ge_m ? rkd_pkg::S_FIX_DIVW : rkd_pkg::S_STORE;
      rkd_pkg::S_FIX_DIVW:  if (!status.div_busy) state_next = rkd_pkg::S_STORE;
      rkd_pkg::S_STORE:
        state_next = phase ? rkd_pkg::S_OUT : rkd_pkg::S_EP;
      rkd_pkg::S_EP:        state_next = rkd_pkg::S_EP_W;
      rkd_pkg::S_EP_W:      if (!status.div_busy) state_next = rkd_pkg::S_EQ;
      rkd_pkg::S_EQ:        state_next = rkd_pkg::S_EQ_W;
      rkd_pkg::S_EQ_W:      if (!status.div_busy) state_next = rkd_pkg::S_INV2_INIT;
      rkd_pkg::S_INV2_INIT: begin
        state_next = rkd_pkg::S_INV_TEST;
        phase_next = 1'b1;
      end
      rkd_pkg::S_OUT:       state_next = rkd_pkg::S_IDLE;
      default:              state_next = rkd_pkg::S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd.op = rkd_pkg::OP_NONE;
    case (state)
      rkd_pkg::S_IDLE:      if (start) cmd.op = rkd_pkg::OP_LOAD;
      rkd_pkg::S_CHECK:     if (!status.in_err) cmd.op = rkd_pkg::OP_MUL_N;
      rkd_pkg::S_N_WAIT:    if (!status.mul_busy) cmd.op = rkd_pkg::OP_SET_N;
      rkd_pkg::S_GCD_INIT:  cmd.op = rkd_pkg::OP_GCD_INIT;
      rkd_pkg::S_GCD_TEST:
        cmd.op = status.nr_zero ? rkd_pkg::OP_LAM_DIV : rkd_pkg::OP_GCD_DIV;
      rkd_pkg::S_GCD_DIVW:  if (!status.div_busy) cmd.op = rkd_pkg::OP_GCD_STEP;
      rkd_pkg::S_LAM_DIVW:  if (!status.div_busy) cmd.op = rkd_pkg::OP_LAM_MUL;
      rkd_pkg::S_LAM_MULW:  if (!status.mul_busy) cmd.op = rkd_pkg::OP_SET_LAM;
      rkd_pkg::S_INV1_INIT: cmd.op = rkd_pkg::OP_INV1_INIT;
      rkd_pkg::S_INV_TEST:
        cmd.op = status.nr_zero ? rkd_pkg::OP_FIX : rkd_pkg::OP_INV_DIV;
      rkd_pkg::S_INV_DIVW:  if (!status.div_busy) cmd.op = rkd_pkg::OP_INV_MUL;
      rkd_pkg::S_INV_MULW:  if (!status.mul_busy) cmd.op = rkd_pkg::OP_INV_STEP;
      rkd_pkg::S_FIX_TEST:  if (status.x_ge_m) cmd.op = rkd_pkg::OP_FIX_DIV;
      rkd_pkg::S_FIX_DIVW:  if (!status.div_busy) cmd.op = rkd_pkg::OP_FIX_REM;
      rkd_pkg::S_STORE:
        cmd.op = phase ? rkd_pkg::OP_SET_CO : rkd_pkg::OP_SET_D;
      rkd_pkg::S_EP:        cmd.op = rkd_pkg::OP_EP_DIV;
      rkd_pkg::S_EP_W:      if (!status.div_busy) cmd.op = rkd_pkg::OP_SET_EP;
      rkd_pkg::S_EQ:        cmd.op = rkd_pkg::OP_EQ_DIV;
      rkd_pkg::S_EQ_W:      if (!status.div_busy) cmd.op = rkd_pkg::OP_SET_EQ;
      rkd_pkg::S_INV2_INIT: cmd.op = rkd_pkg::OP_INV2_INIT;
      rkd_pkg::S_OUT:       cmd.op = rkd_pkg::OP_OUT;
      default:              cmd.op = rkd_pkg::OP_NONE;
    endcase
  end

endmodule

@@ design/rsa_key_derivation_64.sv @@
// Top level of the RSA key derivation block: controller plus datapath.
// Depends on rkd_pkg, rkd_ctrl and rkd_dp.
//
//  channel  signals                       transfer when
//  input    start, busy, item             start && !busy
//  result   done, result                  done (one cycle, no stall)
//  config   cfg_valid, cfg_ready, cfg_data cfg_valid && cfg_ready
//
// One item at a time; the gcd and inverse steps run on a single bit-serial
// divider shared by all steps.
// Synchronous active-high reset; the public exponent resets to 65537.
// The result strobe lasts one cycle and cannot be held off.
module rsa_key_derivation_64 (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  rkd_pkg::item_t             item,
  output logic                       done,
  output rkd_pkg::result_t           result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [rkd_pkg::HALF_W-1:0] cfg_data
);

  rkd_pkg::dp_cmd_t    cmd;
  rkd_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  rkd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .status(status)
  );

  rkd_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status), .item(item),
    .cfg_valid(cfg_valid), .cfg_data(cfg_data), .done(done), .result(result)
  );

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for rsa_key_derivation_64: a predictor computes each key
// from p, q and the public exponent, and every result strobe is compared with it.
// Depends on rkd_pkg and the rsa_key_derivation_64 RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int DRAIN_CYCLES   = 200;

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  rkd_pkg::item_t   item;
  logic      done;
  rkd_pkg::result_t result;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [31:0] cfg_data;

  logic [31:0]      exp_e;
  rkd_pkg::result_t key_queue[$];
  int               error_count;
  int               idle_cycles;

  rsa_key_derivation_64 u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  // Extended Euclid inverse of a modulo m, wrapped into [0, m)
  function automatic logic [63:0] inv_mod(input logic [63:0] a, input logic [63:0] m,
                                          inout logic bad);
    logic [63:0] r, nr, t, nt, qq, lr, lt, res;
    int unsigned steps;
    r = m; nr = a; t = 0; nt = 1; steps = 0;
    while (nr != 0) begin
      qq = r / nr;
      lr = r; lt = t;
      r = nr; t = nt;
      nr = lr - qq * nr;
      nt = lt + qq * nt;
      steps++;
    end
    if (r != 1) bad = 1'b1;
    if (steps != 0 && steps[0] == 1'b0) res = m - t;
    else res = t;
    if (res >= m) res = res % m;
    return res;
  endfunction

  function automatic rkd_pkg::result_t derive_key(input rkd_pkg::item_t it,
                                                  input logic [31:0] e);
    rkd_pkg::result_t k;
    logic [63:0] p, q, pm1, qm1, a, b, tmp, lambda, n, d;
    logic bad;
    k = '0; bad = 1'b0;
    p = {32'd0, it.prime_p}; q = {32'd0, it.prime_q};
    if (p < 2 || q < 2) begin
      k.input_error = 1'b1;
      return k;
    end
    pm1 = p - 1; qm1 = q - 1; n = p * q;
    a = pm1; b = qm1;
    while (b != 0) begin
      tmp = a % b; a = b; b = tmp;
    end
    lambda = (pm1 / a) * qm1;
    d = inv_mod({32'd0, e}, lambda, bad);
    k.modulus = n;
    k.private_exponent = d[62:0];
    tmp = d % pm1; k.exponent_p = tmp[31:0];
    tmp = d % qm1; k.exponent_q = tmp[31:0];
    tmp = inv_mod(q, p, bad); k.crt_coefficient = tmp[31:0];
    k.modulus_full_width = n[63];
    k.not_coprime = bad;
    return k;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  // Check each result strobe against the oldest expected key
  always @(posedge clk) begin
    rkd_pkg::result_t w;
    if (!rst && done) begin
      if (key_queue.size() == 0) begin
        report_mismatch("unexpected result", result.modulus, 0);
      end else begin
        w = key_queue.pop_front();
        if (result.modulus !== w.modulus)
          report_mismatch("modulus", result.modulus, w.modulus);
        if (result.private_exponent !== w.private_exponent)
          report_mismatch("private_exponent", result.private_exponent, w.private_exponent);
        if (result.exponent_p !== w.exponent_p)
          report_mismatch("exponent_p", result.exponent_p, w.exponent_p);
        if (result.exponent_q !== w.exponent_q)
          report_mismatch("exponent_q", result.exponent_q, w.exponent_q);
        if (result.crt_coefficient !== w.crt_coefficient)
          report_mismatch("crt_coefficient", result.crt_coefficient, w.crt_coefficient);
        if (result.modulus_full_width !== w.modulus_full_width)
          report_mismatch("modulus_full_width", result.modulus_full_width,
                          w.modulus_full_width);
        if (result.not_coprime !== w.not_coprime)
          report_mismatch("not_coprime", result.not_coprime, w.not_coprime);
        if (result.input_error !== w.input_error)
          report_mismatch("input_error", result.input_error, w.input_error);
      end
    end
  end

  // Count cycles with no transfer; end the run on a hang
  always @(posedge clk) begin
    if (rst || done || (start && !busy) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  int burst_left;

  // Send one item, with bursts and random gaps ahead of it; keep start high until
  // busy falls, then drop it so the next item never lands in the same step
  task automatic send_key_request(input logic [31:0] p, input logic [31:0] q);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 6);
      repeat ($urandom_range(0, 30)) @(posedge clk);
    end
    burst_left--;
    start <= 1'b1;
    item  <= '{prime_p: p, prime_q: q};
    do @(posedge clk); while (busy);
    key_queue.push_back(derive_key('{prime_p: p, prime_q: q}, exp_e));
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (key_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_exponent(input logic [31:0] e);
    cfg_valid <= 1'b1;
    cfg_data  <= e;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    exp_e = e;
  endtask

  // Draw a factor: mostly small odd values, sometimes full range, 0 to 3 or near the top
  function automatic logic [31:0] rand_factor();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 3);
      2: return 32'hFFFF_FF00 | $urandom_range(0, 255);
      default: return $urandom_range(2, 65535) | 32'd1;
    endcase
  endfunction

  task automatic test_directed();
    send_key_request(32'd61, 32'd53);
    send_key_request(32'd0, 32'd53);
    send_key_request(32'd61, 32'd1);
    send_key_request(32'd1, 32'd0);
    send_key_request(32'd2, 32'd2);
    send_key_request(32'd2, 32'd3);
    send_key_request(32'hFFFF_FFFB, 32'hFFFF_FFEF);
    send_key_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_key_request(32'h8000_0000, 32'hFFFF_FFFF);
    send_key_request(32'd7, 32'd7);
    send_key_request(32'd65537 * 2 + 1, 32'd131071);
    send_key_request(32'h7FFF_FFFF, 32'hAAAA_AAAB);
    send_key_request(32'h5555_5555, 32'd3);
  endtask

  task automatic test_exponent_settings();
    logic [31:0] vals[4];
    vals = '{32'd3, 32'hFFFF_FFFF, 32'd0, 32'd17};
    foreach (vals[i]) begin
      wait_drained();
      write_exponent(vals[i]);
      send_key_request(32'd61, 32'd53);
      send_key_request(32'd11, 32'd3);
      send_key_request(32'hFFFF_FFFB, 32'd65521);
    end
    wait_drained();
    write_exponent(32'd65537);
  endtask

  task automatic test_random();
    for (int i = 0; i < 100; i++) begin
      if (i == 50) begin
        wait_drained();
        write_exponent($urandom_range(3, 1000) | 32'd1);
      end
      send_key_request(rand_factor(), rand_factor());
    end
  endtask

  initial begin
    rst = 1'b1; start = 1'b0; item = '0; cfg_valid = 1'b0; cfg_data = '0;
    exp_e = rkd_pkg::E_RESET; error_count = 0; idle_cycles = 0; burst_left = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_exponent_settings();
    test_random();
    wait_drained();
    if (error_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ files.f @@
design/rkd_pkg.sv
design/rkd_div.sv
design/rkd_mul.sv
design/rkd_dp.sv
design/rkd_ctrl.sv
design/rsa_key_derivation_64.sv
dv/testbench.sv
